@@ rtl/trz_pkg.sv @@
package trz_pkg;

  localparam int DEPTH_BITS = 24;
  localparam int COUNT_BITS = 17;
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS = 9;

  localparam logic [7:0] CLEAR_COLOUR = 8'd138;

  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_DRAW  = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;
  localparam logic [1:0] MODE_NONE  = 2'd3;

  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 1'b1;

  // setup sequence through the shared multiplier
  localparam logic [4:0] STEP_EDGE = 5'd0;
  localparam logic [4:0] STEP_TX   = 5'd6;
  localparam logic [4:0] STEP_TY   = 5'd9;
  localparam logic [4:0] STEP_S    = 5'd12;
  localparam logic [4:0] STEP_END  = 5'd18;

  typedef struct packed {
    logic [1:0]            mode;
    logic signed [15:0]    vertex_a_x;
    logic signed [15:0]    vertex_a_y;
    logic [DEPTH_BITS-1:0] vertex_a_depth;
    logic signed [15:0]    vertex_b_x;
    logic signed [15:0]    vertex_b_y;
    logic [DEPTH_BITS-1:0] vertex_b_depth;
    logic signed [15:0]    vertex_c_x;
    logic signed [15:0]    vertex_c_y;
    logic [DEPTH_BITS-1:0] vertex_c_depth;
    logic [7:0]            fill_colour;
    logic [15:0]           read_index;
  } trz_req_t;

  typedef struct packed {
    logic [7:0]            read_colour;
    logic [DEPTH_BITS-1:0] read_depth;
    logic [COUNT_BITS-1:0] pixels_written;
    logic                  triangle_skipped;
  } trz_rsp_t;

  typedef struct packed {
    logic       load;
    logic       clr_start;
    logic       clr_write;
    logic       mul_valid;
    logic [4:0] mul_idx;
    logic       flip;
    logic       walk_init;
    logic       advance;
    logic       div_start;
    logic       div_step;
    logic       write_test;
    logic       set_skip;
    logic       read_issue;
    logic       read_capture;
    logic       out_load;
  } trz_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       box_empty;
    logic       area_zero;
    logic       covered;
    logic       last_x;
    logic       last_y;
    logic       clr_last;
    logic       out_busy;
  } trz_status_t;

endpackage

@@ rtl/triangle_raster_zbuffer.sv @@
// channel   direction  handshake             payload
// req       in         req_valid/req_stall   trz_req_t (mode, vertices, colour, index)
// rsp       out        rsp_valid/rsp_stall   trz_rsp_t (read data, count, skip flag)
// cfg       in         cfg_we                cfg_index, cfg_data
//
// Draw: setup steps on the shared multiplier, then a walk over the box pixels,
// with a bit-serial depth divide and a store update for each covered pixel.
// Clear: all MAX_WIDTH*MAX_HEIGHT entries, one entry a cycle. Read: a registered
// store read. After reset the same clearing pass runs with req_stall high.
// One item at a time; the next item is taken while a result
// waits in the output register under rsp_stall.
module triangle_raster_zbuffer #(
  parameter int MAX_WIDTH     = 256,
  parameter int MAX_HEIGHT    = 256,
  parameter int SUBPIXEL_BITS = 4
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_stall,
  input  trz_pkg::trz_req_t                  req_item,
  output logic                               rsp_valid,
  input  logic                               rsp_stall,
  output trz_pkg::trz_rsp_t                  rsp_item,
  input  logic                               cfg_we,
  input  logic [trz_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [trz_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  trz_pkg::trz_cmd_t    cmd;
  trz_pkg::trz_status_t stat;

  trz_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  trz_datapath #(
    .MAX_WIDTH     (MAX_WIDTH),
    .MAX_HEIGHT    (MAX_HEIGHT),
    .SUBPIXEL_BITS (SUBPIXEL_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req_item  (req_item),
    .rsp_item  (rsp_item),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

@@ rtl/trz_ram.sv @@
module trz_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/trz_ctrl.sv @@
module trz_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  trz_pkg::trz_status_t stat,
  output trz_pkg::trz_cmd_t    cmd
);

  typedef enum logic [11:0] {
    ST_CLEAR    = 12'b000000000001,
    ST_IDLE     = 12'b000000000010,
    ST_DISPATCH = 12'b000000000100,
    ST_SETUP    = 12'b000000001000,
    ST_FLIP     = 12'b000000010000,
    ST_WALK     = 12'b000000100000,
    ST_PIX      = 12'b000001000000,
    ST_DIV      = 12'b000010000000,
    ST_WRITE    = 12'b000100000000,
    ST_READ     = 12'b001000000000,
    ST_RWAIT    = 12'b010000000000,
    ST_FINISH   = 12'b100000000000
  } state_t;

  state_t     state, state_next;
  logic [4:0] cnt, cnt_next;
  logic       clr_reply, clr_reply_next;

  assign req_stall = (state != ST_IDLE);

  always_comb begin
    cmd            = '0;
    state_next     = state;
    cnt_next       = cnt;
    clr_reply_next = clr_reply;
    case (state)
      ST_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (stat.clr_last) begin
          state_next = clr_reply ? ST_FINISH : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (stat.mode)
          trz_pkg::MODE_CLEAR: begin
            cmd.clr_start  = 1'b1;
            clr_reply_next = 1'b1;
            state_next     = ST_CLEAR;
          end
          trz_pkg::MODE_DRAW: begin
            cnt_next   = trz_pkg::STEP_EDGE;
            state_next = stat.box_empty ? ST_FINISH : ST_SETUP;
          end
          trz_pkg::MODE_READ: state_next = ST_READ;
          default:            state_next = ST_FINISH;
        endcase
      end
      ST_SETUP: begin
        if (cnt != trz_pkg::STEP_END) begin
          cmd.mul_valid = 1'b1;
          cmd.mul_idx   = cnt;
          cnt_next      = cnt + 5'd1;
        end else begin
          state_next = ST_FLIP;
        end
      end
      ST_FLIP: begin
        cmd.flip   = 1'b1;
        state_next = ST_WALK;
      end
      ST_WALK: begin
        if (stat.area_zero) begin
          cmd.set_skip = 1'b1;
          state_next   = ST_FINISH;
        end else begin
          cmd.walk_init = 1'b1;
          state_next    = ST_PIX;
        end
      end
      ST_PIX: begin
        if (stat.covered) begin
          cmd.div_start = 1'b1;
          cnt_next      = 5'd0;
          state_next    = ST_DIV;
        end else begin
          cmd.advance = 1'b1;
          if (stat.last_x && stat.last_y) begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 5'd1;
        if (cnt == 5'(trz_pkg::DEPTH_BITS - 1)) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd.write_test = 1'b1;
        cmd.advance    = 1'b1;
        state_next     = (stat.last_x && stat.last_y) ? ST_FINISH : ST_PIX;
      end
      ST_READ: begin
        cmd.read_issue = 1'b1;
        state_next     = ST_RWAIT;
      end
      ST_RWAIT: begin
        cmd.read_capture = 1'b1;
        state_next       = ST_FINISH;
      end
      ST_FINISH: begin
        if (!stat.out_busy) begin
          cmd.out_load   = 1'b1;
          clr_reply_next = 1'b0;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      cnt       <= 5'd0;
      clr_reply <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      clr_reply <= clr_reply_next;
    end
  end

endmodule

@@ rtl/trz_datapath.sv @@
module trz_datapath #(
  parameter int MAX_WIDTH     = 256,
  parameter int MAX_HEIGHT    = 256,
  parameter int SUBPIXEL_BITS = 4
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  trz_pkg::trz_req_t                     req_item,
  output trz_pkg::trz_rsp_t                     rsp_item,
  output logic                                  rsp_valid,
  input  logic                                  rsp_stall,
  input  logic                                  cfg_we,
  input  logic [trz_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [trz_pkg::CFG_DATA_BITS-1:0]     cfg_data,
  input  trz_pkg::trz_cmd_t                     cmd,
  output trz_pkg::trz_status_t                  stat
);

  localparam int DB    = trz_pkg::DEPTH_BITS;
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int STORE = MAX_WIDTH * MAX_HEIGHT;
  localparam int AWD   = $clog2(STORE);
  localparam int MAXD  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int PW    = $clog2(((2 * MAXD - 1) << SUBPIXEL_BITS) + 65537) + 1;
  localparam int DW    = 18;
  localparam int EW    = DW + PW + 1;
  localparam int EL    = EW / 2;
  localparam int EH    = EW - EL;
  localparam int OW0   = (PW > DW) ? PW : DW;
  localparam int OW1   = (OW0 > DB + 1) ? OW0 : DB + 1;
  localparam int OW2   = (OW1 > EL + 1) ? OW1 : EL + 1;
  localparam int OW    = (OW2 > EH) ? OW2 : EH;
  localparam int AW    = EW + 2;
  localparam int TW    = DW + DB + 2;
  localparam int SW    = EW + DB + 2;
  localparam int SH    = SUBPIXEL_BITS + 1;
  localparam int BW    = 18;
  localparam int SUBM  = (1 << SUBPIXEL_BITS) - 1;

  function automatic logic signed [15:0] min3s(input logic signed [15:0] a,
                                               input logic signed [15:0] b,
                                               input logic signed [15:0] c);
    logic signed [15:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic logic signed [15:0] max3s(input logic signed [15:0] a,
                                               input logic signed [15:0] b,
                                               input logic signed [15:0] c);
    logic signed [15:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  // lane (edge or vertex) served by a setup step
  function automatic logic [1:0] step_lane(input logic [4:0] k);
    logic [4:0] j;
    j = 5'd0;
    if (k < trz_pkg::STEP_TX) begin
      j = k >> 1;
    end else if (k < trz_pkg::STEP_TY) begin
      j = k - trz_pkg::STEP_TX;
    end else if (k < trz_pkg::STEP_S) begin
      j = k - trz_pkg::STEP_TY;
    end else begin
      j = (k - trz_pkg::STEP_S) >> 1;
    end
    return j[1:0];
  endfunction

  // configuration
  logic [trz_pkg::CFG_DATA_BITS-1:0] frame_width, frame_height;
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;

  assign w_eff = (frame_width == '0) ? WW'(1) :
                 (32'(frame_width) > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(frame_width);
  assign h_eff = (frame_height == '0) ? HW'(1) :
                 (32'(frame_height) > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(frame_height);

  // bounding box of the incoming item
  logic signed [15:0]   mnx, mxx, mny, mxy;
  logic signed [BW-1:0] fx0, cx1, fy0, cy1, bx0, bx1, by0, by1, xlim, ylim;
  logic                 box_empty_in;

  always_comb begin
    mnx  = min3s(req_item.vertex_a_x, req_item.vertex_b_x, req_item.vertex_c_x);
    mxx  = max3s(req_item.vertex_a_x, req_item.vertex_b_x, req_item.vertex_c_x);
    mny  = min3s(req_item.vertex_a_y, req_item.vertex_b_y, req_item.vertex_c_y);
    mxy  = max3s(req_item.vertex_a_y, req_item.vertex_b_y, req_item.vertex_c_y);
    fx0  = BW'(mnx) >>> SUBPIXEL_BITS;
    fy0  = BW'(mny) >>> SUBPIXEL_BITS;
    cx1  = (BW'(mxx) + BW'(SUBM)) >>> SUBPIXEL_BITS;
    cy1  = (BW'(mxy) + BW'(SUBM)) >>> SUBPIXEL_BITS;
    xlim = $signed(BW'(w_eff)) - BW'(1);
    ylim = $signed(BW'(h_eff)) - BW'(1);
    bx0  = (fx0 < 0) ? BW'(0) : fx0;
    by0  = (fy0 < 0) ? BW'(0) : fy0;
    bx1  = (cx1 > xlim) ? xlim : cx1;
    by1  = (cy1 > ylim) ? ylim : cy1;
    box_empty_in = (bx0 > bx1) || (by0 > by1);
  end

  // doubled vertex coordinates of the incoming item
  logic signed [16:0] vx_in [3];
  logic signed [16:0] vy_in [3];

  always_comb begin
    vx_in[0] = {req_item.vertex_a_x, 1'b0};
    vx_in[1] = {req_item.vertex_b_x, 1'b0};
    vx_in[2] = {req_item.vertex_c_x, 1'b0};
    vy_in[0] = {req_item.vertex_a_y, 1'b0};
    vy_in[1] = {req_item.vertex_b_y, 1'b0};
    vy_in[2] = {req_item.vertex_c_y, 1'b0};
  end

  // latched item
  logic [1:0]           mode_q;
  logic                 box_empty_q;
  logic [XW-1:0]        x0q, x1q, xq;
  logic [YW-1:0]        y0q, y1q, yq;
  logic signed [16:0]   px [3];
  logic signed [16:0]   py [3];
  logic signed [DW-1:0] dx [3];
  logic signed [DW-1:0] dy [3];
  logic [DB-1:0]        z [3];
  logic [7:0]           colour_q;
  logic [15:0]          rdidx_q;

  // setup and walk state
  logic signed [EW-1:0]     e [3];
  logic signed [EW-1:0]     er [3];
  logic signed [EW-1:0]     stx [3];
  logic signed [EW-1:0]     sty [3];
  logic signed [TW-1:0]     tx, ty;
  logic signed [SW-1:0]     s, sr, sx, sy;
  logic [AW-1:0]            amag;
  logic signed [AW-1:0]     area;
  logic                     area_zero_q;
  logic [AWD-1:0]           rowbase, pix_idx;
  logic signed [PW-1:0]     xc, yc;
  logic signed [PW-1:0]     xd [3];
  logic signed [PW-1:0]     yd [3];

  // multiplier
  logic signed [OW-1:0]     a_op, b_op;
  logic signed [2*OW-1:0]   prod;
  logic [4:0]               p_idx;
  logic                     p_valid;
  logic [1:0]               msel, psel;
  logic signed [SW-1:0]     s_term;

  // divider
  logic [SW-1:0]            rem, dv;
  logic [DB-1:0]            q;

  // results
  logic [7:0]                      res_colour;
  logic [DB-1:0]                   res_depth;
  logic [trz_pkg::COUNT_BITS-1:0]  res_count;
  logic                            res_skip;
  logic                            rd_in_range;

  // stores
  logic [AWD-1:0] clr_addr, ram_waddr, ram_raddr;
  logic           ram_we, ram_re, better;
  logic [7:0]     colour_wdata, colour_rdata;
  logic [DB-1:0]  depth_wdata, depth_rdata;

  always_comb begin
    xc = PW'({x0q, 1'b1}) << SUBPIXEL_BITS;
    yc = PW'({y0q, 1'b1}) << SUBPIXEL_BITS;
    for (int i = 0; i < 3; i++) begin
      xd[i]  = xc - PW'(px[(i + 1) % 3]);
      yd[i]  = yc - PW'(py[(i + 1) % 3]);
      stx[i] = -(EW'(dy[i]) <<< SH);
      sty[i] = EW'(dx[i]) <<< SH;
    end
    sx   = -(SW'(tx) <<< SH);
    sy   = SW'(ty) <<< SH;
    area = AW'(e[0]) + AW'(e[1]) + AW'(e[2]);
    pix_idx = rowbase + AWD'(xq);
  end

  // operand selection for the setup sequence
  always_comb begin
    a_op = '0;
    b_op = '0;
    msel = step_lane(cmd.mul_idx);
    if (cmd.mul_idx < trz_pkg::STEP_TX) begin
      if (!cmd.mul_idx[0]) begin
        a_op = OW'(dx[msel]);
        b_op = OW'(yd[msel]);
      end else begin
        a_op = OW'(dy[msel]);
        b_op = OW'(xd[msel]);
      end
    end else if (cmd.mul_idx < trz_pkg::STEP_TY) begin
      a_op = OW'(dy[msel]);
      b_op = OW'({1'b0, z[msel]});
    end else if (cmd.mul_idx < trz_pkg::STEP_S) begin
      a_op = OW'(dx[msel]);
      b_op = OW'({1'b0, z[msel]});
    end else begin
      if (!cmd.mul_idx[0]) begin
        a_op = OW'({1'b0, e[msel][EL-1:0]});
      end else begin
        a_op = OW'($signed(e[msel][EW-1:EL]));
      end
      b_op = OW'({1'b0, z[msel]});
    end
  end

  always_comb begin
    psel   = step_lane(p_idx);
    s_term = p_idx[0] ? (SW'(prod) <<< EL) : SW'(prod);
  end

  assign rd_in_range = (32'(rdidx_q) < 32'(STORE));
  assign better      = (q > depth_rdata);

  always_comb begin
    ram_we       = cmd.clr_write | (cmd.write_test & better);
    ram_waddr    = cmd.clr_write ? clr_addr : pix_idx;
    colour_wdata = cmd.clr_write ? trz_pkg::CLEAR_COLOUR : colour_q;
    depth_wdata  = cmd.clr_write ? '0 : q;
    ram_re       = cmd.read_issue | cmd.div_start;
    ram_raddr    = cmd.read_issue ? AWD'(rdidx_q) : pix_idx;
  end

  trz_ram #(.WIDTH(8), .DEPTH(STORE)) u_colour_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (colour_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (colour_rdata)
  );

  trz_ram #(.WIDTH(DB), .DEPTH(STORE)) u_depth_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (depth_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (depth_rdata)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= 9'd256;
      frame_height <= 9'd256;
      rsp_valid    <= 1'b0;
      clr_addr     <= '0;
      p_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          trz_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data;
          trz_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (cmd.clr_start) begin
        clr_addr <= '0;
      end else if (cmd.clr_write) begin
        clr_addr <= clr_addr + AWD'(1);
      end
      p_valid <= cmd.mul_valid;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q      <= req_item.mode;
      box_empty_q <= box_empty_in;
      x0q         <= XW'(bx0);
      x1q         <= XW'(bx1);
      y0q         <= YW'(by0);
      y1q         <= YW'(by1);
      xq          <= XW'(bx0);
      yq          <= YW'(by0);
      for (int i = 0; i < 3; i++) begin
        px[i] <= vx_in[i];
        py[i] <= vy_in[i];
        dx[i] <= DW'(vx_in[(i + 2) % 3]) - DW'(vx_in[(i + 1) % 3]);
        dy[i] <= DW'(vy_in[(i + 2) % 3]) - DW'(vy_in[(i + 1) % 3]);
      end
      z[0]       <= req_item.vertex_a_depth;
      z[1]       <= req_item.vertex_b_depth;
      z[2]       <= req_item.vertex_c_depth;
      colour_q   <= req_item.fill_colour;
      rdidx_q    <= req_item.read_index;
      res_colour <= '0;
      res_depth  <= '0;
      res_count  <= '0;
      res_skip   <= (req_item.mode == trz_pkg::MODE_DRAW) && box_empty_in;
    end

    if (cmd.mul_valid) begin
      prod  <= a_op * b_op;
      p_idx <= cmd.mul_idx;
    end

    if (p_valid) begin
      if (p_idx < trz_pkg::STEP_TX) begin
        if (!p_idx[0]) begin
          e[psel] <= EW'(prod);
        end else begin
          e[psel] <= e[psel] - EW'(prod);
        end
      end else if (p_idx < trz_pkg::STEP_TY) begin
        tx <= (p_idx == trz_pkg::STEP_TX) ? TW'(prod) : tx + TW'(prod);
      end else if (p_idx < trz_pkg::STEP_S) begin
        ty <= (p_idx == trz_pkg::STEP_TY) ? TW'(prod) : ty + TW'(prod);
      end else begin
        s <= (p_idx == trz_pkg::STEP_S) ? s_term : s + s_term;
      end
    end

    // orient everything so that the area is not negative
    if (cmd.flip) begin
      area_zero_q <= (area == '0);
      amag        <= area[AW-1] ? AW'(-area) : AW'(area);
      rowbase     <= AWD'(y0q) * AWD'(w_eff);
      if (area[AW-1]) begin
        for (int i = 0; i < 3; i++) begin
          e[i]  <= -e[i];
          dx[i] <= -dx[i];
          dy[i] <= -dy[i];
        end
        s  <= -s;
        tx <= -tx;
        ty <= -ty;
      end
    end

    if (cmd.walk_init) begin
      for (int i = 0; i < 3; i++) begin
        er[i] <= e[i];
      end
      sr <= s;
    end

    if (cmd.advance) begin
      if (xq == x1q) begin
        xq      <= x0q;
        yq      <= yq + YW'(1);
        rowbase <= rowbase + AWD'(w_eff);
        for (int i = 0; i < 3; i++) begin
          er[i] <= er[i] + sty[i];
          e[i]  <= er[i] + sty[i];
        end
        sr <= sr + sy;
        s  <= sr + sy;
      end else begin
        xq <= xq + XW'(1);
        for (int i = 0; i < 3; i++) begin
          e[i] <= e[i] + stx[i];
        end
        s <= s + sx;
      end
    end

    if (cmd.div_start) begin
      rem <= s;
      dv  <= SW'(amag) << (DB - 1);
      q   <= '0;
    end else if (cmd.div_step) begin
      if (rem >= dv) begin
        rem <= rem - dv;
        q   <= {q[DB-2:0], 1'b1};
      end else begin
        q   <= {q[DB-2:0], 1'b0};
      end
      dv <= dv >> 1;
    end

    if (cmd.write_test && better && (res_count != '1)) begin
      res_count <= res_count + trz_pkg::COUNT_BITS'(1);
    end

    if (cmd.set_skip) begin
      res_skip <= 1'b1;
    end

    if (cmd.read_capture) begin
      res_colour <= rd_in_range ? colour_rdata : '0;
      res_depth  <= rd_in_range ? depth_rdata : '0;
    end

    if (cmd.out_load) begin
      rsp_item.read_colour      <= res_colour;
      rsp_item.read_depth       <= res_depth;
      rsp_item.pixels_written   <= res_count;
      rsp_item.triangle_skipped <= res_skip;
    end
  end

  always_comb begin
    stat.mode      = mode_q;
    stat.box_empty = box_empty_q;
    stat.area_zero = area_zero_q;
    stat.covered   = !e[0][EW-1] && !e[1][EW-1] && !e[2][EW-1];
    stat.last_x    = (xq == x1q);
    stat.last_y    = (yq == y1q);
    stat.clr_last  = (clr_addr == AWD'(STORE - 1));
    stat.out_busy  = rsp_valid && rsp_stall;
  end

endmodule

@@ rtl/trz_checker.sv @@
module trz_checker (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_stall,
  input trz_pkg::trz_req_t req_item,
  input logic              rsp_valid,
  input logic              rsp_stall,
  input trz_pkg::trz_rsp_t rsp_item
);

  // hold a stalled result
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
    else $error("stalled result changed");

  // the clearing pass after reset blocks input
  a_reset_clear: assert property (@(posedge clk)
    rst |=> req_stall)
    else $error("input taken during reset clear");

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("second item taken while busy");

  a_skip_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_item.triangle_skipped |-> rsp_item.pixels_written == '0)
    else $error("skipped triangle reports written pixels");

  a_read_only: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_item.read_colour != '0 || rsp_item.read_depth != '0)
      |-> rsp_item.pixels_written == '0 && !rsp_item.triangle_skipped)
    else $error("read data mixed with draw result");

endmodule

bind triangle_raster_zbuffer trz_checker u_trz_checker (.*);

@@ tb/triangle_raster_zbuffer_tb.sv @@
module triangle_raster_zbuffer_tb;

  localparam int STORE_SIZE = 65536;
  localparam int WATCH_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  trz_pkg::trz_req_t req_item = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  trz_pkg::trz_rsp_t rsp_item;
  logic cfg_we = 1'b0;
  logic [trz_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [trz_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;

  // model of the frame and depth stores
  logic [7:0] colour_mem [STORE_SIZE];
  logic [trz_pkg::DEPTH_BITS-1:0] depth_mem [STORE_SIZE];
  logic [8:0] frame_w_reg = 9'd256;
  logic [8:0] frame_h_reg = 9'd256;

  trz_pkg::trz_rsp_t expected_rsp [$];
  int fails = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int last_cx = 8;
  int last_cy = 8;

  triangle_raster_zbuffer dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req_item(req_item),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_item(rsp_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic longint edge_fn(longint px, longint py, longint qx, longint qy,
                                     longint x, longint y);
    return (qx - px) * (y - py) - (qy - py) * (x - px);
  endfunction

  function automatic longint eff_size(logic [8:0] r);
    if (r == 0) return 1;
    return (r > 256) ? 256 : longint'(r);
  endfunction

  function automatic void wipe_stores();
    for (int i = 0; i < STORE_SIZE; i++) begin
      colour_mem[i] = trz_pkg::CLEAR_COLOUR;
      depth_mem[i] = '0;
    end
  endfunction

  function automatic trz_pkg::trz_rsp_t raster_triangle(trz_pkg::trz_req_t r);
    trz_pkg::trz_rsp_t o;
    longint ax, ay, bx, by, cx, cy, area, sgn, w, h, x0, x1, y0, y1, px, py, ea, eb, ec;
    bit [63:0] za, zb, zc, amag, hi, lo, q, rm, d, idx, count;
    o = '0;
    o.triangle_skipped = 1'b1;
    ax = longint'(r.vertex_a_x); ay = longint'(r.vertex_a_y);
    bx = longint'(r.vertex_b_x); by = longint'(r.vertex_b_y);
    cx = longint'(r.vertex_c_x); cy = longint'(r.vertex_c_y);
    za = 64'(r.vertex_a_depth); zb = 64'(r.vertex_b_depth); zc = 64'(r.vertex_c_depth);
    w = eff_size(frame_w_reg);
    h = eff_size(frame_h_reg);
    area = edge_fn(2*ax, 2*ay, 2*bx, 2*by, 2*cx, 2*cy);
    if (area == 0) return o;
    sgn = (area > 0) ? 1 : -1;
    amag = area * sgn;
    x0 = ((ax < bx ? (ax < cx ? ax : cx) : (bx < cx ? bx : cx))) >>> 4;
    y0 = ((ay < by ? (ay < cy ? ay : cy) : (by < cy ? by : cy))) >>> 4;
    x1 = -((-(ax > bx ? (ax > cx ? ax : cx) : (bx > cx ? bx : cx))) >>> 4);
    y1 = -((-(ay > by ? (ay > cy ? ay : cy) : (by > cy ? by : cy))) >>> 4);
    if (x0 < 0) x0 = 0;
    if (y0 < 0) y0 = 0;
    if (x1 > w - 1) x1 = w - 1;
    if (y1 > h - 1) y1 = h - 1;
    if (x0 > x1 || y0 > y1) return o;
    o.triangle_skipped = 1'b0;
    count = 0;
    for (longint y = y0; y <= y1; y++) begin
      py = (2*y + 1) * 16;
      for (longint x = x0; x <= x1; x++) begin
        px = (2*x + 1) * 16;
        ea = edge_fn(2*bx, 2*by, 2*cx, 2*cy, px, py) * sgn;
        eb = edge_fn(2*cx, 2*cy, 2*ax, 2*ay, px, py) * sgn;
        ec = edge_fn(2*ax, 2*ay, 2*bx, 2*by, px, py) * sgn;
        if (ea < 0 || eb < 0 || ec < 0) continue;
        hi = ea * (za >> 16) + eb * (zb >> 16) + ec * (zc >> 16);
        lo = ea * (za & 16'hFFFF) + eb * (zb & 16'hFFFF) + ec * (zc & 16'hFFFF);
        q = hi / amag;
        rm = hi % amag;
        d = ((q << 16) + ((rm << 16) + lo) / amag) & 64'hFFFFFF;
        idx = y * w + x;
        if (idx >= STORE_SIZE) continue;
        if (d > depth_mem[idx[15:0]]) begin
          depth_mem[idx[15:0]] = d[trz_pkg::DEPTH_BITS-1:0];
          colour_mem[idx[15:0]] = r.fill_colour;
          if (count < 131071) count++;
        end
      end
    end
    o.pixels_written = count[trz_pkg::COUNT_BITS-1:0];
    return o;
  endfunction

  function automatic trz_pkg::trz_rsp_t frame_result(trz_pkg::trz_req_t r);
    trz_pkg::trz_rsp_t o;
    o = '0;
    case (r.mode)
      trz_pkg::MODE_CLEAR: wipe_stores();
      trz_pkg::MODE_DRAW: o = raster_triangle(r);
      trz_pkg::MODE_READ: begin
        o.read_colour = colour_mem[r.read_index];
        o.read_depth = depth_mem[r.read_index];
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic trz_pkg::trz_req_t mk_draw(int ax, int ay, int za, int bx, int by,
                                                int zb, int cx, int cy, int zc, int colour);
    trz_pkg::trz_req_t r;
    r = '0;
    r.mode = trz_pkg::MODE_DRAW;
    r.vertex_a_x = 16'(ax); r.vertex_a_y = 16'(ay); r.vertex_a_depth = 24'(za);
    r.vertex_b_x = 16'(bx); r.vertex_b_y = 16'(by); r.vertex_b_depth = 24'(zb);
    r.vertex_c_x = 16'(cx); r.vertex_c_y = 16'(cy); r.vertex_c_depth = 24'(zc);
    r.fill_colour = 8'(colour);
    return r;
  endfunction

  function automatic trz_pkg::trz_req_t mk_op(logic [1:0] mode, int index);
    trz_pkg::trz_req_t r;
    r = '0;
    r.mode = mode;
    r.read_index = 16'(index);
    return r;
  endfunction

  // small triangle near a random spot, sometimes straddling the frame edge
  function automatic trz_pkg::trz_req_t rand_draw();
    trz_pkg::trz_req_t r;
    int w, h;
    w = int'(eff_size(frame_w_reg));
    h = int'(eff_size(frame_h_reg));
    last_cx = $urandom_range(w + 8) - 4;
    last_cy = $urandom_range(h + 8) - 4;
    r = mk_draw(last_cx*16 + $urandom_range(128) - 64, last_cy*16 + $urandom_range(128) - 64,
                $urandom_range(24'hFFFFFF),
                last_cx*16 + $urandom_range(128) - 64, last_cy*16 + $urandom_range(128) - 64,
                $urandom_range(24'hFFFFFF),
                last_cx*16 + $urandom_range(128) - 64, last_cy*16 + $urandom_range(128) - 64,
                $urandom_range(24'hFFFFFF), $urandom_range(255));
    r.read_index = 16'($urandom);
    return r;
  endfunction

  task automatic send_item(trz_pkg::trz_req_t r);
    while ($urandom_range(99) < send_idle) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_item <= r;
    do @(posedge clk); while (req_stall);
    expected_rsp.push_back(frame_result(r));
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [trz_pkg::CFG_INDEX_BITS-1:0] index, logic [8:0] value);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (index == trz_pkg::REG_FRAME_WIDTH) frame_w_reg = value;
    else frame_h_reg = value;
    @(posedge clk);
  endtask

  task automatic set_frame(logic [8:0] w, logic [8:0] h);
    drain();
    write_reg(trz_pkg::REG_FRAME_WIDTH, w);
    write_reg(trz_pkg::REG_FRAME_HEIGHT, h);
  endtask

  task automatic test_directed();
    send_item(mk_op(trz_pkg::MODE_READ, 0));
    send_item(mk_op(trz_pkg::MODE_READ, 65535));
    send_item(mk_draw(32, 32, 24'h100000, 160, 48, 24'h200000, 64, 144, 24'h300000, 200));
    // opposite winding, nearer
    send_item(mk_draw(32, 32, 24'h400000, 64, 144, 24'h500000, 160, 48, 24'h600000, 55));
    // farther, nothing passes the depth test
    send_item(mk_draw(32, 32, 24'h000010, 160, 48, 24'h000010, 64, 144, 24'h000010, 9));
    send_item(mk_op(trz_pkg::MODE_READ, 4*256 + 4));
    send_item(mk_draw(0, 0, 100, 80, 80, 200, 160, 160, 300, 1));
    send_item(mk_draw(-320, -320, 100, -160, -300, 200, -200, -160, 300, 2));
    // edges through pixel centres
    send_item(mk_draw(20*16+8, 20*16+8, 24'hFFFFFF, 30*16+8, 20*16+8, 24'hFFFFFF,
                      20*16+8, 30*16+8, 24'hFFFFFF, 255));
    send_item(mk_op(trz_pkg::MODE_READ, 20*256 + 20));
    send_item(mk_draw(250*16, 250*16, 0, 262*16, 251*16, 0, 251*16, 262*16, 0, 3));
    send_item(mk_draw(240*16, 240*16, 24'h800000, 265*16, 245*16, 24'h7FFFFF,
                      245*16, 265*16, 24'hABCDEF, 77));
    send_item(mk_op(trz_pkg::MODE_READ, 255*256 + 255));
    send_item(mk_op(trz_pkg::MODE_NONE, 5));
    send_item(mk_op(trz_pkg::MODE_CLEAR, 0));
    send_item(mk_op(trz_pkg::MODE_READ, 20*256 + 20));
  endtask

  task automatic test_frame_extremes();
    set_frame(4, 4);
    send_item(mk_draw(-32768, -32768, 24'hFFFFFF, 32767, -32768, 24'hFFFFFF,
                      -32768, 32767, 24'hFFFFFF, 11));
    send_item(mk_draw(32767, 32767, 24'h000001, -32768, 32767, 24'hFFFFFF,
                      32767, -32768, 24'h7FFFFF, 12));
    send_item(mk_op(trz_pkg::MODE_READ, 3*4 + 3));
    set_frame(1, 1);
    send_item(mk_draw(-64, -64, 24'hFFFFFF, 64, -32, 24'hFFFFFF, 0, 64, 24'hFFFFFF, 13));
    send_item(mk_op(trz_pkg::MODE_READ, 0));
    set_frame(0, 0);
    send_item(mk_draw(-64, -64, 24'h1, 64, -32, 24'h2, 0, 64, 24'h3, 14));
    send_item(mk_draw(32, 32, 24'h1, 64, 32, 24'h2, 32, 64, 24'h3, 14));
    set_frame(511, 511);
    send_item(mk_draw(4000, 4000, 24'h123456, 4200, 4010, 24'h654321,
                      4050, 4200, 24'h0F0F0F, 15));
    send_item(mk_op(trz_pkg::MODE_READ, 255*256 + 254));
  endtask

  task automatic test_random(int s_idle, int r_idle, int w, int h, int n);
    trz_pkg::trz_req_t r;
    int pick;
    set_frame(9'(w), 9'(h));
    send_idle = s_idle;
    recv_idle = r_idle;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 60) r = rand_draw();
      else if (pick < 90) begin
        r = mk_op(trz_pkg::MODE_READ, 0);
        r.read_index = 16'(eff_size(frame_w_reg) * (last_cy + $urandom_range(4) - 2)
                           + last_cx + $urandom_range(4) - 2);
      end else if (pick < 97) r = mk_op(trz_pkg::MODE_READ, $urandom);
      else r = mk_op(trz_pkg::MODE_NONE, $urandom);
      send_item(r);
    end
  endtask

  // fully random fields in a tiny frame so the clamped box stays cheap
  task automatic test_noise(int n);
    trz_pkg::trz_req_t r;
    logic [223:0] noise;
    set_frame(16, 16);
    send_item(mk_op(trz_pkg::MODE_CLEAR, 0));
    for (int i = 0; i < n; i++) begin
      noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      r = noise[$bits(trz_pkg::trz_req_t)-1:0];
      if (r.mode == trz_pkg::MODE_CLEAR) r.mode = trz_pkg::MODE_DRAW;
      send_item(r);
    end
  endtask

  task automatic test_pressure();
    drain();
    send_idle = 0;
    recv_idle = 0;
    hold_left = 400;
    for (int i = 0; i < 8; i++) send_item(mk_op(trz_pkg::MODE_READ, $urandom));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (hold_left > 0) begin
      rsp_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      rsp_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  always @(posedge clk) begin
    trz_pkg::trz_rsp_t e;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsp.size() == 0) begin
        $error("unexpected result %h", rsp_item);
        fails++;
      end else begin
        e = expected_rsp.pop_front();
        if (rsp_item.read_colour !== e.read_colour) begin
          $error("read_colour exp %0d got %0d", e.read_colour, rsp_item.read_colour);
          fails++;
        end
        if (rsp_item.read_depth !== e.read_depth) begin
          $error("read_depth exp %0d got %0d", e.read_depth, rsp_item.read_depth);
          fails++;
        end
        if (rsp_item.pixels_written !== e.pixels_written) begin
          $error("pixels_written exp %0d got %0d", e.pixels_written, rsp_item.pixels_written);
          fails++;
        end
        if (rsp_item.triangle_skipped !== e.triangle_skipped) begin
          $error("triangle_skipped exp %0d got %0d", e.triangle_skipped,
                 rsp_item.triangle_skipped);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCH_LIMIT) begin
      $display("triangle_raster_zbuffer: mismatch");
      $finish;
    end
  end

  initial begin
    wipe_stores();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_frame_extremes();
    test_random(0, 0, 256, 256, 200);
    test_random(63, 0, 100, 60, 200);
    test_random(0, 63, 37, 255, 200);
    test_random(22, 22, 256, 256, 200);
    test_noise(60);
    test_pressure();
    drain();
    repeat (30) @(posedge clk);
    if (fails == 0) $display("triangle_raster_zbuffer: match");
    else $display("triangle_raster_zbuffer: mismatch");
    $finish;
  end

endmodule

@@ files.f @@
rtl/trz_pkg.sv
rtl/trz_ram.sv
rtl/trz_ctrl.sv
rtl/trz_datapath.sv
rtl/triangle_raster_zbuffer.sv
rtl/trz_checker.sv
tb/triangle_raster_zbuffer_tb.sv
